// ----- hdl/cvs_pkg.sv -----
// Shared types and constants for the CIR variance Euler step unit.
`default_nettype none

package cvs_pkg;

    // Square root chain: radicand is the Q16.16 variance shifted up by 16 bits
    localparam int VAR_W      = 32;
    localparam int RAD_W      = VAR_W + 16;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int REM_W      = ROOT_W + 2;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_RATE  = 3'd0;
    localparam logic [2:0] REG_LEVEL = 3'd1;
    localparam logic [2:0] REG_VOL   = 3'd2;
    localparam logic [2:0] REG_DT    = 3'd3;
    localparam logic [2:0] REG_RDT   = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] reversion_rate;
        logic [DATA_W-1:0] long_run_level;
        logic [DATA_W-1:0] vol_of_vol;
        logic [DATA_W-1:0] step_length;
        logic [DATA_W-1:0] root_step_length;
    } cvs_cfg_t;

    typedef struct packed {
        logic [VAR_W-1:0]        variance;
        logic signed [VAR_W-1:0] draw;
        logic                    last;
    } cvs_item_t;

    typedef struct packed {
        cvs_item_t         item;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } cvs_cell_t;

endpackage

`default_nettype wire

// ----- hdl/cvs_root_cell.sv -----
// One cell of the square root chain: resolves one root bit per transaction.
`default_nettype none

module cvs_root_cell
    import cvs_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire cvs_cell_t in_data,
    output logic           in_ready,
    output logic           out_valid,
    output cvs_cell_t      out_data,
    input  wire logic      out_ready
);

    // Radicand bit pair consumed by this cell, most significant pair first
    localparam int BIT_LO = 2 * (ROOT_STEPS - 1 - STEP);

    logic              valid_reg;
    cvs_cell_t         data_reg;
    cvs_cell_t         data_next;
    logic [RAD_W-1:0]  radicand;
    logic [1:0]        pair;
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  reduced;
    logic              take_bit;

    // Trial subtract of (4*root + 1) from the shifted remainder
    always_comb
    begin
        radicand  = {in_data.item.variance, 16'b0};
        pair      = radicand[BIT_LO+1:BIT_LO];
        cand      = {in_data.rem, pair};
        trial     = {2'b00, in_data.root, 2'b01};
        reduced   = cand - trial;
        take_bit  = (cand >= trial);
        data_next = in_data;
        data_next.rem  = take_bit ? reduced[REM_W-1:0] : cand[REM_W-1:0];
        data_next.root = {in_data.root[ROOT_W-2:0], take_bit};
    end

    // Advance when empty or when the neighbor takes the held transaction
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

    // Remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem <= {1'b0, data_reg.root, 1'b0}))
        else $error("root cell remainder out of bound");

endmodule

`default_nettype wire

// ----- hdl/cvs_step_math.sv -----
// Drift, diffusion, exact sum, reflection and rounding pipeline.
`default_nettype none

module cvs_step_math
    import cvs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cvs_cfg_t  cfg,
    input  wire logic      in_valid,
    input  wire cvs_cell_t in_data,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_stall,
    output logic [31:0]    next_variance,
    output logic           last_out
);

    localparam int NSTAGE = 9;

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] en;

    // Stage 0: compare, draw magnitude, sigma * root
    logic [31:0] v0_reg, diff0_reg, zmag0_reg;
    logic        last0_reg, dneg0_reg, zneg0_reg;
    logic [55:0] sr0_reg;
    logic [31:0] diff0_next, zmag0_next, zraw;
    logic        dneg0_next;
    logic [55:0] sr0_next;

    // Stage 1: k * |theta - v|, sr * root_dt partials
    logic [31:0] v1_reg, zmag1_reg;
    logic        last1_reg, dneg1_reg, zneg1_reg;
    logic [63:0] p1_reg, srtb1_reg;
    logic [55:0] srta1_reg;
    logic [63:0] p1_next, srtb1_next;
    logic [55:0] srta1_next;

    // Stage 2: p * dt partials, srt sum
    logic [31:0] v2_reg, zmag2_reg;
    logic        last2_reg, dneg2_reg, zneg2_reg;
    logic [63:0] pa2_reg, pb2_reg;
    logic [55:0] srt2_reg;
    logic [63:0] pa2_next, pb2_next;
    logic [55:0] srt2_next;

    // Stage 3: drift sum, srt * |z| partials
    logic [31:0] v3_reg;
    logic        last3_reg, dneg3_reg, zneg3_reg;
    logic [62:0] drift3_reg;
    logic [55:0] da3_reg;
    logic [63:0] db3_reg;
    logic [64:0] drift_sum;
    logic [62:0] drift3_next;
    logic [55:0] da3_next;
    logic [63:0] db3_next;

    // Stage 4: diffusion sum
    logic [31:0] v4_reg;
    logic        last4_reg, dneg4_reg, zneg4_reg;
    logic [62:0] drift4_reg, diffu4_reg;
    logic [62:0] diffu4_next;

    // Stage 5..8: signed sum, reflection, rounding
    logic        last5_reg, zneg5_reg;
    logic [62:0] diffu5_reg;
    logic [65:0] part5_reg, part5_next, vterm;
    logic        last6_reg;
    logic [65:0] tot6_reg, tot6_next;
    logic        last7_reg;
    logic [65:0] mag7_reg, mag7_next;
    logic        last8_reg;
    logic [31:0] res8_reg, res8_next;
    logic [65:0] rounded;

    // Bubble-collapsing advance: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || !out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0 logic
    always_comb
    begin
        dneg0_next = in_data.item.variance > cfg.long_run_level;
        diff0_next = dneg0_next ? in_data.item.variance - cfg.long_run_level
                                : cfg.long_run_level - in_data.item.variance;
        zraw       = in_data.item.draw;
        // the most negative draw wraps to magnitude 2^31, which is exact
        zmag0_next = zraw[31] ? (~zraw + 32'd1) : zraw;
        sr0_next   = 56'(cfg.vol_of_vol) * 56'(in_data.root);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            v0_reg    <= in_data.item.variance;
            last0_reg <= in_data.item.last;
            dneg0_reg <= dneg0_next;
            diff0_reg <= diff0_next;
            zneg0_reg <= in_data.item.draw[31];
            zmag0_reg <= zmag0_next;
            sr0_reg   <= sr0_next;
        end
    end

    // Stage 1 logic
    always_comb
    begin
        p1_next    = 64'(diff0_reg) * 64'(cfg.reversion_rate);
        srta1_next = 56'(sr0_reg[55:32]) * 56'(cfg.root_step_length);
        srtb1_next = 64'(sr0_reg[31:0]) * 64'(cfg.root_step_length);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            v1_reg    <= v0_reg;
            last1_reg <= last0_reg;
            dneg1_reg <= dneg0_reg;
            zneg1_reg <= zneg0_reg;
            zmag1_reg <= zmag0_reg;
            p1_reg    <= p1_next;
            srta1_reg <= srta1_next;
            srtb1_reg <= srtb1_next;
        end
    end

    // Stage 2 logic
    always_comb
    begin
        pa2_next  = 64'(p1_reg[63:32]) * 64'(cfg.step_length);
        pb2_next  = 64'(p1_reg[31:0]) * 64'(cfg.step_length);
        srt2_next = srta1_reg + 56'(srtb1_reg[63:32]);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            dneg2_reg <= dneg1_reg;
            zneg2_reg <= zneg1_reg;
            zmag2_reg <= zmag1_reg;
            pa2_reg   <= pa2_next;
            pb2_reg   <= pb2_next;
            srt2_reg  <= srt2_next;
        end
    end

    // Stage 3 logic: drift in units of 2^-31
    always_comb
    begin
        drift_sum   = 65'(pa2_reg) + 65'(pb2_reg[63:32]);
        drift3_next = drift_sum[63:1];
        da3_next    = 56'(srt2_reg[55:32]) * 56'(zmag2_reg);
        db3_next    = 64'(srt2_reg[31:0]) * 64'(zmag2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            v3_reg     <= v2_reg;
            last3_reg  <= last2_reg;
            dneg3_reg  <= dneg2_reg;
            zneg3_reg  <= zneg2_reg;
            drift3_reg <= drift3_next;
            da3_reg    <= da3_next;
            db3_reg    <= db3_next;
        end
    end

    // Stage 4 logic: diffusion in units of 2^-31
    assign diffu4_next = {da3_reg, 7'b0} + 63'(db3_reg[63:25]);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            v4_reg     <= v3_reg;
            last4_reg  <= last3_reg;
            dneg4_reg  <= dneg3_reg;
            zneg4_reg  <= zneg3_reg;
            drift4_reg <= drift3_reg;
            diffu4_reg <= diffu4_next;
        end
    end

    // Stage 5 logic: variance plus signed drift
    always_comb
    begin
        vterm      = {19'b0, v4_reg, 15'b0};
        part5_next = dneg4_reg ? vterm - {3'b0, drift4_reg} : vterm + {3'b0, drift4_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            last5_reg  <= last4_reg;
            zneg5_reg  <= zneg4_reg;
            diffu5_reg <= diffu4_reg;
            part5_reg  <= part5_next;
        end
    end

    // Stage 6 logic: add signed diffusion
    assign tot6_next = zneg5_reg ? part5_reg - {3'b0, diffu5_reg}
                                 : part5_reg + {3'b0, diffu5_reg};

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            last6_reg <= last5_reg;
            tot6_reg  <= tot6_next;
        end
    end

    // Stage 7 logic: reflect negative totals
    assign mag7_next = tot6_reg[65] ? (66'd0 - tot6_reg) : tot6_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            last7_reg <= last6_reg;
            mag7_reg  <= mag7_next;
        end
    end

    // Stage 8 logic: round half up to Q16.16 and saturate
    always_comb
    begin
        rounded   = mag7_reg + 66'd16384;
        res8_next = (|rounded[65:47]) ? 32'hFFFF_FFFF : rounded[46:15];
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            last8_reg <= last7_reg;
            res8_reg  <= res8_next;
        end
    end

    assign next_variance = res8_reg;
    assign last_out      = last8_reg;

    // Reflected magnitude is never negative
    a_mag_positive: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[7] |-> !mag7_reg[65])
        else $error("reflected magnitude has sign bit set");

endmodule

`default_nettype wire

// ----- hdl/cir_variance_euler_step_unit.sv -----
// Top level of the CIR variance Euler step unit: registers, root chain, step pipeline.
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+-------------------------------------------
//  in       | in_valid / in_stall      | current_variance, normal_draw, last_path
//  out      | out_valid / out_stall    | next_variance, last_out
//  config   | psel, penable, pwrite    | paddr, pwdata, prdata, pready
//
//  One transaction per cycle while out_stall is low: 24 root cells, one bit each, then
//  9 arithmetic stages with one multiplier rank or one wide add per stage.
//  Reset clears all valid bits and the configuration registers to zero.
//  out_stall holds the final stage; empty stages keep filling, and in_stall rises
//  only when every stage holds a transaction.
`default_nettype none

module cir_variance_euler_step_unit
    import cvs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        current_variance,
    input  wire logic signed [31:0] normal_draw,
    input  wire logic               last_path,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [31:0]             next_variance,
    output logic                    last_out
);

    cvs_cfg_t              cfg_reg;
    logic [2:0]            reg_index;
    logic                  cfg_write;
    cvs_cell_t             entry_data;
    logic [ROOT_STEPS:0]   cell_valid;
    logic [ROOT_STEPS:0]   cell_ready;
    cvs_cell_t             cell_data [ROOT_STEPS+1];

    // Register decode
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_RATE:  cfg_reg.reversion_rate   <= pwdata;
                REG_LEVEL: cfg_reg.long_run_level   <= pwdata;
                REG_VOL:   cfg_reg.vol_of_vol       <= pwdata;
                REG_DT:    cfg_reg.step_length      <= pwdata;
                REG_RDT:   cfg_reg.root_step_length <= pwdata;
                default:   ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_index)
            REG_RATE:  prdata = cfg_reg.reversion_rate;
            REG_LEVEL: prdata = cfg_reg.long_run_level;
            REG_VOL:   prdata = cfg_reg.vol_of_vol;
            REG_DT:    prdata = cfg_reg.step_length;
            REG_RDT:   prdata = cfg_reg.root_step_length;
            default:   prdata = '0;
        endcase
    end

    // Launch a transaction into the root chain with a cleared remainder
    always_comb
    begin
        entry_data               = '0;
        entry_data.item.variance = current_variance;
        entry_data.item.draw     = normal_draw;
        entry_data.item.last     = last_path;
    end

    assign cell_valid[0] = in_valid;
    assign cell_data[0]  = entry_data;
    assign in_stall      = !cell_ready[0];

    // Square root chain, one cell per root bit
    genvar g;
    generate
        for (g = 0; g < ROOT_STEPS; g++)
        begin : g_cell
            cvs_root_cell #(
                .STEP (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (cell_valid[g]),
                .in_data   (cell_data[g]),
                .in_ready  (cell_ready[g]),
                .out_valid (cell_valid[g+1]),
                .out_data  (cell_data[g+1]),
                .out_ready (cell_ready[g+1])
            );
        end
    endgenerate

    // Step arithmetic and output register
    cvs_step_math u_math (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (cell_valid[ROOT_STEPS]),
        .in_data       (cell_data[ROOT_STEPS]),
        .in_ready      (cell_ready[ROOT_STEPS]),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_variance (next_variance),
        .last_out      (last_out)
    );

    // Input stalls only when the output holds a result
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");

    // Chain output is the integer square root of the radicand
    a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[ROOT_STEPS] |->
            (({26'b0, cell_data[ROOT_STEPS].root} * {26'b0, cell_data[ROOT_STEPS].root})
                <= {2'b0, cell_data[ROOT_STEPS].item.variance, 16'b0})
            && ((({26'b0, cell_data[ROOT_STEPS].root} + 50'd1)
                * ({26'b0, cell_data[ROOT_STEPS].root} + 50'd1))
                > {2'b0, cell_data[ROOT_STEPS].item.variance, 16'b0}))
        else $error("root chain result is not the integer square root");

    // A write to the step length register lands on the next edge
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && reg_index == REG_DT) |=> (cfg_reg.step_length == $past(pwdata)))
        else $error("step length register write lost");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the CIR variance Euler step unit.
`timescale 1ns / 100ps

module testbench;
    import cvs_pkg::*;

    localparam int MAX_GAP      = 13;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_ITEMS  = 75;
    localparam int RANDOM_SETS  = 10;
    localparam int PRINT_LIMIT  = 100;

    // Addresses past the register list; writes there must be dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Q-format landmarks used by the directed paths
    localparam logic [31:0] DRAW_MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] DRAW_MOST_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] DRAW_MINUS_4  = 32'hFC00_0000;
    localparam logic [31:0] DRAW_MINUS_3  = 32'hFD00_0000;

    typedef struct {
        logic [31:0] variance;
        logic [31:0] draw;
        logic [31:0] next_variance;
        logic        last;
    } variance_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    wire  [DATA_W-1:0] prdata;
    wire               pready;
    logic              in_valid = 1'b0;
    wire               in_stall;
    logic [31:0]       current_variance = '0;
    logic signed [31:0] normal_draw = '0;
    logic              last_path = 1'b0;
    wire               out_valid;
    logic              out_stall = 1'b0;
    wire  [31:0]       next_variance;
    wire               last_out;

    cvs_item_t         pending_paths[$];
    variance_result_t  expected_variances[$];
    cvs_cfg_t          model_regs = '0;
    cvs_item_t         offered_path;
    variance_result_t  predicted;
    variance_result_t  oldest;

    int   error_count = 0;
    bit   sender_idles = 1'b1;
    bit   receiver_idles = 1'b1;
    int   hold_requests = 0;
    int   holds_served = 0;
    int   send_gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;

    cir_variance_euler_step_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .current_variance (current_variance),
        .normal_draw      (normal_draw),
        .last_path        (last_path),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .next_variance    (next_variance),
        .last_out         (last_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bail out if the run hangs
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Floor square root of a 48-bit radicand, one bit per pass
    function automatic logic [23:0] floor_root(input logic [47:0] radicand);
        logic [23:0] r;
        logic [47:0] sq;
        r = '0;
        for (int b = 23; b >= 0; b--)
        begin
            r[b] = 1'b1;
            sq = r * r;
            if (sq > radicand)
                r[b] = 1'b0;
        end
        return r;
    endfunction

    // Euler step with reflection, exact sum in units of 2^-31, rounded half up
    function automatic logic [31:0] stepped_variance(input cvs_cfg_t regs,
                                                     input logic [31:0] v,
                                                     input logic [31:0] z);
        logic         toward_zero;
        logic         z_neg;
        logic [31:0]  level_gap;
        logic [32:0]  z_mag;
        logic [23:0]  root;
        logic [127:0] drift;
        logic [127:0] spread;
        logic [127:0] diffusion;
        logic [127:0] up;
        logic [127:0] down;
        logic [127:0] mag;
        logic [127:0] rounded;
        toward_zero = v > regs.long_run_level;
        level_gap = toward_zero ? v - regs.long_run_level : regs.long_run_level - v;
        drift = (regs.reversion_rate * level_gap * regs.step_length) >> 33;
        z_neg = z[31];
        z_mag = z_neg ? (33'h1_0000_0000 - {1'b0, z}) : {1'b0, z};
        root = floor_root({v, 16'h0000});
        spread = (regs.vol_of_vol * root * regs.root_step_length) >> 32;
        diffusion = (spread * z_mag) >> 25;
        up = {96'b0, v} << 15;
        down = '0;
        if (toward_zero)
            down = down + drift;
        else
            up = up + drift;
        if (z_neg)
            down = down + diffusion;
        else
            up = up + diffusion;
        mag = (up >= down) ? up - down : down - up;
        rounded = (mag + (128'd1 << 14)) >> 15;
        return (rounded > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : rounded[31:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic bit busy();
        return pending_paths.size() != 0 || in_valid || expected_variances.size() != 0;
    endfunction

    // Sender: hold a stalled transaction, else wait out the gap and offer the next path
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_fire))
        begin
            if (in_valid && in_fire)
                send_gap_left = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
            if (send_gap_left > 0)
            begin
                send_gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_paths.size() != 0)
            begin
                offered_path = pending_paths.pop_front();
                current_variance <= offered_path.variance;
                normal_draw <= offered_path.draw;
                last_path <= offered_path.last;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Predict each accepted path at the edge where it is taken
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            predicted.variance = current_variance;
            predicted.draw = normal_draw;
            predicted.next_variance = stepped_variance(model_regs, current_variance,
                                                       normal_draw);
            predicted.last = last_path;
            expected_variances.push_back(predicted);
        end
    end

    // Receiver: long hold on request, otherwise a random stall after each result when idling
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_fire)
                stall_left = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        out_fire <= rst_n && out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_variances.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result next_variance=%h last_out=%b",
                                          next_variance, last_out));
            end
            else
            begin
                oldest = expected_variances.pop_front();
                if (next_variance !== oldest.next_variance)
                    report_mismatch($sformatf("v=%h z=%h next_variance got %h want %h",
                                              oldest.variance, oldest.draw,
                                              next_variance, oldest.next_variance));
                if (last_out !== oldest.last)
                    report_mismatch($sformatf("v=%h z=%h last_out got %b want %b",
                                              oldest.variance, oldest.draw,
                                              last_out, oldest.last));
            end
        end
    end

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_RATE:  model_regs.reversion_rate = value;
            REG_LEVEL: model_regs.long_run_level = value;
            REG_VOL:   model_regs.vol_of_vol = value;
            REG_DT:    model_regs.step_length = value;
            REG_RDT:   model_regs.root_step_length = value;
            default:   ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] rate, input logic [31:0] level,
                                 input logic [31:0] vol, input logic [31:0] dt,
                                 input logic [31:0] rdt);
        write_register(REG_RATE, rate);
        write_register(REG_LEVEL, level);
        write_register(REG_VOL, vol);
        write_register(REG_DT, dt);
        write_register(REG_RDT, rdt);
        @(posedge clk);
    endtask

    // Plausible market parameters with dt a power of four so the root is exact
    task automatic load_plausible_settings();
        int n;
        n = 2 * $urandom_range(2, 6);
        load_settings($urandom_range(0, 32'h000A_0000), $urandom_range(0, 32'h0001_0000),
                      $urandom_range(0, 32'h0002_0000), 32'h1 << (32 - n),
                      32'h1 << (32 - n / 2));
    endtask

    task automatic wait_idle();
        while (busy())
            @(posedge clk);
    endtask

    task automatic add_path(input logic [31:0] v, input logic [31:0] z, input logic last);
        cvs_item_t p;
        p.variance = v;
        p.draw = z;
        p.last = last;
        pending_paths.push_back(p);
    endtask

    function automatic logic [31:0] random_variance();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return model_regs.long_run_level + $urandom_range(0, 8) - 4;
            3, 4: return $urandom;
            default: return $urandom_range(0, 32'h0002_0000);
        endcase
    endfunction

    function automatic logic [31:0] random_draw();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return DRAW_MOST_NEG;
                    1: return DRAW_MOST_POS;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default:
            begin
                mag = $urandom_range(0, 32'h0600_0000);
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    task automatic add_random_paths(input int count);
        for (int i = 0; i < count; i++)
            add_path(random_variance(), random_draw(), $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Typical setting, then writes past the register list that must be dropped
        load_settings(32'h0002_0000, 32'h0000_0A3D, 32'h0000_4CCC, 32'h0100_0000,
                      32'h1000_0000);
        write_register(REG_SPARE_LO, 32'hDEAD_BEEF);
        write_register(REG_SPARE_HI, 32'h1234_5678);
        add_path(32'h0000_0000, 32'h0000_0000, 1'b0);
        add_path(32'h0000_0000, DRAW_MOST_POS, 1'b1);
        add_path(32'h0000_0000, DRAW_MOST_NEG, 1'b0);
        add_path(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        add_path(32'hFFFF_FFFF, DRAW_MOST_POS, 1'b0);
        add_path(32'hFFFF_FFFF, DRAW_MOST_NEG, 1'b1);
        add_path(32'h0000_0A3D, 32'h0000_0000, 1'b0);
        add_path(32'h0000_0A3D, 32'hFFFF_FFFF, 1'b0);
        add_path(32'h0000_0A3E, 32'h0000_0001, 1'b1);
        // Small variance with a strongly negative draw goes below zero and reflects
        add_path(32'h0000_0100, DRAW_MINUS_4, 1'b0);
        add_path(32'h0000_028F, DRAW_MINUS_3, 1'b1);
        add_path(32'h0001_0000, 32'h0100_0000, 1'b0);
        wait_idle();

        // Every register at its maximum drives results into saturation
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
        add_path(32'hFFFF_FFFF, DRAW_MOST_POS, 1'b1);
        add_path(32'h0000_0000, DRAW_MOST_POS, 1'b0);
        add_path(32'h8000_0000, DRAW_MOST_NEG, 1'b1);
        add_path(32'h0000_0001, DRAW_MOST_NEG, 1'b0);
        wait_idle();

        // Zero drift and diffusion pass the variance through
        load_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        add_path(32'hFFFF_FFFF, DRAW_MOST_NEG, 1'b1);
        add_path(32'h1234_5678, DRAW_MOST_POS, 1'b0);
        add_path(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // Random sets, each under its own register setting and idling mode
        for (int set = 0; set < RANDOM_SETS; set++)
        begin
            case (set)
                0: load_settings(32'h0002_0000, 32'h0000_0A3D, 32'h0000_4CCC,
                                 32'h0100_0000, 32'h1000_0000);
                2, 8: load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
                3: load_settings($urandom_range(0, 32'h000A_0000), $urandom_range(0, 32'h0001_0000),
                                 $urandom_range(0, 32'h0002_0000), $urandom, $urandom);
                4: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF);
                5: load_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
                default: load_plausible_settings();
            endcase
            sender_idles = (set % 3) != 2;
            receiver_idles = (set % 3) != 2;
            // Hold the receiver off while the sender streams, filling the pipeline
            if (set == 6)
            begin
                sender_idles = 1'b0;
                hold_requests++;
            end
            add_random_paths(PHASE_ITEMS);
            wait_idle();
        end

        // Drain, then watch for stray results
        for (int guard = 0; guard < DRAIN_LIMIT && busy(); guard++)
            @(posedge clk);
        if (expected_variances.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_variances.size()));
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/cvs_pkg.sv
hdl/cvs_root_cell.sv
hdl/cvs_step_math.sv
hdl/cir_variance_euler_step_unit.sv
test/testbench.sv
